FILE: design/ccdc_pkg.sv
// Shared types, codes and constants of the confirmed command drive controller.
package ccdc_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_FWD   = 3'd1,
    MODE_BACK  = 3'd2,
    MODE_LEFT  = 3'd3,
    MODE_RIGHT = 3'd4,
    MODE_SPINL = 3'd5,
    MODE_SPINR = 3'd6,
    MODE_BRAKE = 3'd7
  } mode_e;

  typedef enum logic [3:0] {
    SND_NONE  = 4'd0,
    SND_FWD   = 4'd2,
    SND_BACK  = 4'd3,
    SND_LEFT  = 4'd4,
    SND_RIGHT = 4'd5,
    SND_STOP  = 4'd6,
    SND_UP    = 4'd7,
    SND_DOWN  = 4'd8,
    SND_ERROR = 4'd9
  } sound_e;

  // Recognizer command codes.
  localparam logic [7:0] CMD_FWD   = 8'd1;
  localparam logic [7:0] CMD_BACK  = 8'd2;
  localparam logic [7:0] CMD_LEFT  = 8'd3;
  localparam logic [7:0] CMD_RIGHT = 8'd4;
  localparam logic [7:0] CMD_BRAKE = 8'd5;
  localparam logic [7:0] CMD_UP    = 8'd6;
  localparam logic [7:0] CMD_DOWN  = 8'd7;
  localparam logic [7:0] CMD_SPINL = 8'd8;
  localparam logic [7:0] CMD_SPINR = 8'd9;

  // H-bridge pin patterns.
  localparam logic [3:0] PINS_OFF   = 4'h0;
  localparam logic [3:0] PINS_FWD   = 4'h5;
  localparam logic [3:0] PINS_BACK  = 4'hA;
  localparam logic [3:0] PINS_SPINL = 4'h6;
  localparam logic [3:0] PINS_SPINR = 4'h9;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd7;

  // Reset values of the registers.
  localparam logic [7:0]  CONFIRM_RST = 8'd2;
  localparam logic [11:0] BASE_RST    = 12'd500;
  localparam logic [11:0] MAX_RST     = 12'd900;
  localparam logic [11:0] MIN_RST     = 12'd200;
  localparam logic [11:0] STEP_RST    = 12'd100;
  localparam logic [11:0] PERIOD_RST  = 12'd1000;
  localparam logic [15:0] BRAKE_RST   = 16'd150;
  localparam logic [15:0] TIMEOUT_RST = 16'd3000;

  localparam int unsigned HEARTBEAT_TICKS_DEF = 500;

  // Reciprocal of three for 12-bit values: floor(x * 2731 / 8192) == x / 3.
  localparam logic [12:0] THIRD_MUL = 13'd2731;

  typedef struct packed {
    logic [7:0]  confirm_count;
    logic [11:0] max_speed;
    logic [11:0] min_speed;
    logic [11:0] speed_step;
    logic [11:0] brake_duty;
    logic [15:0] brake_ticks;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic        load;
    logic [11:0] value;
  } speed_load_t;

  typedef struct packed {
    logic       action;
    logic [7:0] code;
  } item_t;

endpackage

FILE: design/ccdc_cfg.sv
// Configuration register file with the speed preset strobe.
module ccdc_cfg import ccdc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o,
  output speed_load_t           speed_load_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CONFIRM: cfg_d.confirm_count = cfg_data_i[7:0];
        REG_MAX:     cfg_d.max_speed     = cfg_data_i[11:0];
        REG_MIN:     cfg_d.min_speed     = cfg_data_i[11:0];
        REG_STEP:    cfg_d.speed_step    = cfg_data_i[11:0];
        REG_PERIOD:  cfg_d.brake_duty    = cfg_data_i[11:0];
        REG_BRAKE:   cfg_d.brake_ticks   = cfg_data_i[15:0];
        REG_TIMEOUT: cfg_d.timeout_ticks = cfg_data_i[15:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.confirm_count <= CONFIRM_RST;
      cfg_q.max_speed     <= MAX_RST;
      cfg_q.min_speed     <= MIN_RST;
      cfg_q.speed_step    <= STEP_RST;
      cfg_q.brake_duty    <= PERIOD_RST;
      cfg_q.brake_ticks   <= BRAKE_RST;
      cfg_q.timeout_ticks <= TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The base speed is not kept: writing it presets the speed register directly.
  assign speed_load_o.load  = cfg_we_i && (cfg_index_i == REG_BASE);
  assign speed_load_o.value = cfg_data_i[11:0];
  assign cfg_o              = cfg_q;

endmodule

FILE: design/ccdc_core.sv
// Command confirmation, drive state update and result register.
module ccdc_core import ccdc_pkg::*; #(
  parameter int unsigned HeartbeatTicks = HEARTBEAT_TICKS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  speed_load_t speed_load_i,
  input  logic        item_valid_i,
  input  item_t       item_i,
  output logic        take_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  drive_pins_o,
  output logic [11:0] left_duty_o,
  output logic [11:0] right_duty_o,
  output logic [3:0]  sound_number_o,
  output logic [2:0]  drive_mode_o,
  output logic [11:0] speed_level_o,
  output logic        run_led_o,
  output logic        executed_o
);

  mode_e       mode_q, mode_d;
  sound_e      sound_q, sound_d;
  logic [11:0] speed_q, speed_d;
  logic [7:0]  pending_q, pending_d;
  logic [7:0]  repeat_q, repeat_d;
  logic [31:0] tick_q, tick_d;
  logic [31:0] last_cmd_q, last_cmd_d;
  logic [31:0] brake_start_q, brake_start_d;
  logic [31:0] hb_mark_q, hb_mark_d;
  logic [3:0]  pins_q, pins_d;
  logic [11:0] duty_l_q, duty_l_d;
  logic [11:0] duty_r_q, duty_r_d;
  logic        led_q, led_d;
  logic        exec_q, exec_d;
  logic        out_valid_q, out_valid_d;

  logic        take;
  logic        fire;
  logic [7:0]  repeat_inc;
  logic [31:0] tick_nx;
  logic [31:0] brake_age;
  logic [31:0] idle_age;
  logic [31:0] hb_age;
  logic [24:0] third_prod;
  logic [11:0] speed_third;
  logic [12:0] speed_sum;
  logic [12:0] speed_floor;
  logic [11:0] speed_inc;
  logic [11:0] speed_dn;

  assign take = item_valid_i && (!out_valid_q || out_ready_i);

  assign repeat_inc = (repeat_q == 8'hFF) ? repeat_q : repeat_q + 8'd1;
  assign fire = take && !item_i.action && (item_i.code == pending_q) &&
                (repeat_inc >= cfg_i.confirm_count);

  assign tick_nx   = tick_q + 32'd1;
  assign brake_age = tick_nx - brake_start_q;
  assign idle_age  = tick_nx - last_cmd_q;
  assign hb_age    = tick_nx - hb_mark_q;

  assign third_prod  = 25'(speed_q) * 25'(THIRD_MUL);
  assign speed_third = third_prod[24:13];

  assign speed_sum   = {1'b0, speed_q} + {1'b0, cfg_i.speed_step};
  assign speed_inc   = (speed_sum > {1'b0, cfg_i.max_speed}) ? cfg_i.max_speed
                                                             : speed_sum[11:0];
  assign speed_floor = {1'b0, cfg_i.min_speed} + {1'b0, cfg_i.speed_step};
  assign speed_dn    = ({1'b0, speed_q} >= speed_floor) ? speed_q - cfg_i.speed_step
                                                        : cfg_i.min_speed;

  always_comb begin
    mode_d        = mode_q;
    sound_d       = sound_q;
    speed_d       = speed_q;
    pending_d     = pending_q;
    repeat_d      = repeat_q;
    tick_d        = tick_q;
    last_cmd_d    = last_cmd_q;
    brake_start_d = brake_start_q;
    hb_mark_d     = hb_mark_q;
    pins_d        = pins_q;
    duty_l_d      = duty_l_q;
    duty_r_d      = duty_r_q;
    led_d         = led_q;
    exec_d        = exec_q;

    if (take) begin
      sound_d = SND_NONE;
      exec_d  = 1'b0;
      if (!item_i.action) begin
        if (item_i.code != pending_q) begin
          pending_d = item_i.code;
          repeat_d  = 8'd1;
        end else if (!fire) begin
          repeat_d = repeat_inc;
        end else begin
          repeat_d   = 8'd0;
          pending_d  = 8'd0;
          last_cmd_d = tick_q;
          led_d      = !led_q;
          exec_d     = 1'b1;
          case (item_i.code)
            CMD_FWD: begin
              mode_d = MODE_FWD; pins_d = PINS_FWD;
              duty_l_d = speed_q; duty_r_d = speed_q; sound_d = SND_FWD;
            end
            CMD_BACK: begin
              mode_d = MODE_BACK; pins_d = PINS_BACK;
              duty_l_d = speed_q; duty_r_d = speed_q; sound_d = SND_BACK;
            end
            CMD_LEFT: begin
              mode_d = MODE_LEFT; pins_d = PINS_FWD;
              duty_l_d = speed_third; duty_r_d = speed_q; sound_d = SND_LEFT;
            end
            CMD_RIGHT: begin
              mode_d = MODE_RIGHT; pins_d = PINS_FWD;
              duty_l_d = speed_q; duty_r_d = speed_third; sound_d = SND_RIGHT;
            end
            CMD_BRAKE: begin
              mode_d = MODE_BRAKE; brake_start_d = tick_q; pins_d = PINS_OFF;
              duty_l_d = cfg_i.brake_duty; duty_r_d = cfg_i.brake_duty;
              sound_d = SND_STOP;
            end
            CMD_UP, CMD_DOWN: begin
              if (item_i.code == CMD_UP) begin
                speed_d = speed_inc;
                sound_d = SND_UP;
              end else begin
                speed_d = speed_dn;
                sound_d = SND_DOWN;
              end
              // Straight driving picks up the new speed at once; turns keep theirs.
              if (mode_q == MODE_FWD || mode_q == MODE_BACK) begin
                pins_d   = (mode_q == MODE_FWD) ? PINS_FWD : PINS_BACK;
                duty_l_d = speed_d;
                duty_r_d = speed_d;
              end
            end
            CMD_SPINL: begin
              mode_d = MODE_SPINL; pins_d = PINS_SPINL;
              duty_l_d = speed_q; duty_r_d = speed_q; sound_d = SND_LEFT;
            end
            CMD_SPINR: begin
              mode_d = MODE_SPINR; pins_d = PINS_SPINR;
              duty_l_d = speed_q; duty_r_d = speed_q; sound_d = SND_RIGHT;
            end
            default: sound_d = SND_ERROR;
          endcase
        end
      end else begin
        tick_d = tick_nx;
        if (mode_q == MODE_BRAKE && brake_age >= {16'd0, cfg_i.brake_ticks}) begin
          mode_d   = MODE_IDLE;
          pins_d   = PINS_OFF;
          duty_l_d = 12'd0;
          duty_r_d = 12'd0;
        end
        // The timeout sees the mode after the brake end test of the same tick.
        if (mode_d != MODE_IDLE && mode_d != MODE_BRAKE &&
            idle_age >= {16'd0, cfg_i.timeout_ticks}) begin
          mode_d        = MODE_BRAKE;
          brake_start_d = tick_nx;
          pins_d        = PINS_OFF;
          duty_l_d      = cfg_i.brake_duty;
          duty_r_d      = cfg_i.brake_duty;
        end
        if (hb_age >= 32'(HeartbeatTicks)) begin
          hb_mark_d = tick_nx;
          led_d     = !led_q;
        end
      end
    end

    if (speed_load_i.load) begin
      speed_d = speed_load_i.value;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_IDLE;
      sound_q       <= SND_NONE;
      speed_q       <= BASE_RST;
      pending_q     <= 8'd0;
      repeat_q      <= 8'd0;
      tick_q        <= 32'd0;
      last_cmd_q    <= 32'd0;
      brake_start_q <= 32'd0;
      hb_mark_q     <= 32'd0;
      pins_q        <= PINS_OFF;
      duty_l_q      <= 12'd0;
      duty_r_q      <= 12'd0;
      led_q         <= 1'b0;
      exec_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      mode_q        <= mode_d;
      sound_q       <= sound_d;
      speed_q       <= speed_d;
      pending_q     <= pending_d;
      repeat_q      <= repeat_d;
      tick_q        <= tick_d;
      last_cmd_q    <= last_cmd_d;
      brake_start_q <= brake_start_d;
      hb_mark_q     <= hb_mark_d;
      pins_q        <= pins_d;
      duty_l_q      <= duty_l_d;
      duty_r_q      <= duty_r_d;
      led_q         <= led_d;
      exec_q        <= exec_d;
      out_valid_q   <= out_valid_d;
    end
  end

  assign take_o         = take;
  assign out_valid_o    = out_valid_q;
  assign drive_pins_o   = pins_q;
  assign left_duty_o    = duty_l_q;
  assign right_duty_o   = duty_r_q;
  assign sound_number_o = sound_q;
  assign drive_mode_o   = mode_q;
  assign speed_level_o  = speed_q;
  assign run_led_o      = led_q;
  assign executed_o     = exec_q;

  a_exec_has_sound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && exec_q) |-> (sound_q != SND_NONE))
    else $error("executed command without a sound");

  a_exec_clears_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (pending_q == 8'd0 && repeat_q == 8'd0 && exec_q))
    else $error("confirmation state not cleared after execution");

  a_brake_pins_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_BRAKE) |-> (pins_q == PINS_OFF))
    else $error("bridge driven while braking");

  a_idle_outputs_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_IDLE) |-> (pins_q == PINS_OFF && duty_l_q == 12'd0 &&
                               duty_r_q == 12'd0))
    else $error("motor driven while idle");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(mode_q) &&
                                       $stable(sound_q) && $stable(tick_q)))
    else $error("state moved while the result was stalled");

endmodule

FILE: design/confirmed_command_drive_controller.sv
// Top level of the confirmed command drive controller.
// Each request (a command code or a millisecond tick) is captured in an input
// register and from there passes through one stage of compare and add logic
// that updates the drive state and loads the result register; a request is
// therefore accepted in every cycle unless a stalled result holds the input
// register full, with the input register absorbing one request while a result
// waits to be taken. A code executes only when it repeats the pending code
// until the confirm count is reached. The result reports the bridge pins, both
// duties, the mode, the speed, the LED level, the sound to start and whether a
// command executed. Configuration is written through a plain write port; the
// user must write it only while no request is in flight, as the block does
// not enforce it. Writing the base speed presets the speed at once.
module confirmed_command_drive_controller import ccdc_pkg::*; #(
  parameter int unsigned HeartbeatTicks = HEARTBEAT_TICKS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  action_i,
  input  logic [7:0]            code_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [3:0]            drive_pins_o,
  output logic [11:0]           left_duty_o,
  output logic [11:0]           right_duty_o,
  output logic [3:0]            sound_number_o,
  output logic [2:0]            drive_mode_o,
  output logic [11:0]           speed_level_o,
  output logic                  run_led_o,
  output logic                  executed_o
);

  cfg_t        cfg;
  speed_load_t speed_load;
  item_t       item_q;
  logic        item_valid_q;
  logic        take;
  logic        in_ready;

  ccdc_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cfg_o        (cfg),
    .speed_load_o (speed_load)
  );

  assign in_ready = !item_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      item_q.action <= action_i;
      item_q.code   <= code_i;
    end
  end

  ccdc_core #(
    .HeartbeatTicks (HeartbeatTicks)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .speed_load_i   (speed_load),
    .item_valid_i   (item_valid_q),
    .item_i         (item_q),
    .take_o         (take),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .drive_pins_o   (drive_pins_o),
    .left_duty_o    (left_duty_o),
    .right_duty_o   (right_duty_o),
    .sound_number_o (sound_number_o),
    .drive_mode_o   (drive_mode_o),
    .speed_level_o  (speed_level_o),
    .run_led_o      (run_led_o),
    .executed_o     (executed_o)
  );

  assign in_ready_o = in_ready;

endmodule

FILE: dv/confirmed_command_drive_controller_tb.sv
// Self-checking testbench of the confirmed command drive controller.
module confirmed_command_drive_controller_tb;
  import ccdc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASES = 10;
  localparam logic [7:0] CODE_ZERO = 8'h00;
  localparam logic [7:0] CODE_TOP  = 8'hFF;

  typedef struct {
    item_t req;
    bit    drain;
  } queued_req_t;

  typedef struct {
    logic [3:0]  pins;
    logic [11:0] left_duty;
    logic [11:0] right_duty;
    sound_e      sound;
    mode_e       mode;
    logic [11:0] speed;
    logic        led;
    logic        executed;
  } car_state_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  action_i = 1'b0;
  logic [7:0]            code_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [3:0]            drive_pins_o;
  logic [11:0]           left_duty_o;
  logic [11:0]           right_duty_o;
  logic [3:0]            sound_number_o;
  logic [2:0]            drive_mode_o;
  logic [11:0]           speed_level_o;
  logic                  run_led_o;
  logic                  executed_o;

  confirmed_command_drive_controller uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .code_i        (code_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .drive_pins_o  (drive_pins_o),
    .left_duty_o   (left_duty_o),
    .right_duty_o  (right_duty_o),
    .sound_number_o(sound_number_o),
    .drive_mode_o  (drive_mode_o),
    .speed_level_o (speed_level_o),
    .run_led_o     (run_led_o),
    .executed_o    (executed_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predicted configuration of the block.
  logic [7:0]  cfg_confirm = CONFIRM_RST;
  logic [11:0] cfg_max     = MAX_RST;
  logic [11:0] cfg_min     = MIN_RST;
  logic [11:0] cfg_step    = STEP_RST;
  logic [11:0] cfg_period  = PERIOD_RST;
  logic [15:0] cfg_brake   = BRAKE_RST;
  logic [15:0] cfg_timeout = TIMEOUT_RST;

  // Predicted car state.
  mode_e       car_mode      = MODE_IDLE;
  logic [11:0] car_speed     = BASE_RST;
  logic [7:0]  pend_code     = '0;
  logic [7:0]  pend_hits     = '0;
  logic [31:0] tick_now      = '0;
  logic [31:0] last_cmd_tick = '0;
  logic [31:0] brake_tick    = '0;
  logic [31:0] beat_tick     = '0;
  logic [3:0]  bridge_pins   = '0;
  logic [11:0] duty_l        = '0;
  logic [11:0] duty_r        = '0;
  logic        led_on        = 1'b0;

  queued_req_t req_q[$];
  car_state_t  car_state_q[$];

  bit req_done = 0;
  bit res_done = 0;
  bit send_idle = 1;
  bit recv_idle = 1;
  int send_wait = 0;
  int recv_wait = 0;
  int stall_cycles = 0;
  int mismatches = 0;

  function automatic void set_bridge(input logic [3:0] pins, input logic [11:0] l,
                                     input logic [11:0] r);
    bridge_pins = pins;
    duty_l = l;
    duty_r = r;
  endfunction

  function automatic void begin_brake();
    car_mode = MODE_BRAKE;
    brake_tick = tick_now;
    set_bridge(PINS_OFF, cfg_period, cfg_period);
  endfunction

  // A speed change only reaches the duties while driving straight.
  function automatic void reload_straight();
    if (car_mode == MODE_FWD) set_bridge(PINS_FWD, car_speed, car_speed);
    else if (car_mode == MODE_BACK) set_bridge(PINS_BACK, car_speed, car_speed);
  endfunction

  function automatic car_state_t next_car_state(input logic act, input logic [7:0] cmd);
    car_state_t res;
    logic [12:0] sum;
    res.sound = SND_NONE;
    res.executed = 1'b0;
    if (!act) begin
      if (cmd == pend_code) begin
        if (pend_hits != 8'hFF) pend_hits++;
        if (pend_hits >= cfg_confirm) begin
          pend_hits = '0;
          pend_code = '0;
          last_cmd_tick = tick_now;
          led_on = ~led_on;
          res.executed = 1'b1;
          case (cmd)
            CMD_FWD: begin
              car_mode = MODE_FWD;
              set_bridge(PINS_FWD, car_speed, car_speed);
              res.sound = SND_FWD;
            end
            CMD_BACK: begin
              car_mode = MODE_BACK;
              set_bridge(PINS_BACK, car_speed, car_speed);
              res.sound = SND_BACK;
            end
            CMD_LEFT: begin
              car_mode = MODE_LEFT;
              set_bridge(PINS_FWD, car_speed / 12'd3, car_speed);
              res.sound = SND_LEFT;
            end
            CMD_RIGHT: begin
              car_mode = MODE_RIGHT;
              set_bridge(PINS_FWD, car_speed, car_speed / 12'd3);
              res.sound = SND_RIGHT;
            end
            CMD_BRAKE: begin
              begin_brake();
              res.sound = SND_STOP;
            end
            CMD_UP: begin
              sum = {1'b0, car_speed} + {1'b0, cfg_step};
              car_speed = (sum > {1'b0, cfg_max}) ? cfg_max : sum[11:0];
              reload_straight();
              res.sound = SND_UP;
            end
            CMD_DOWN: begin
              if ({1'b0, car_speed} >= {1'b0, cfg_min} + {1'b0, cfg_step})
                car_speed = car_speed - cfg_step;
              else
                car_speed = cfg_min;
              reload_straight();
              res.sound = SND_DOWN;
            end
            CMD_SPINL: begin
              car_mode = MODE_SPINL;
              set_bridge(PINS_SPINL, car_speed, car_speed);
              res.sound = SND_LEFT;
            end
            CMD_SPINR: begin
              car_mode = MODE_SPINR;
              set_bridge(PINS_SPINR, car_speed, car_speed);
              res.sound = SND_RIGHT;
            end
            default: res.sound = SND_ERROR;
          endcase
        end
      end else begin
        pend_code = cmd;
        pend_hits = 8'd1;
      end
    end else begin
      tick_now++;
      // The brake end test comes first, so a brake begun by timeout lasts at
      // least until the next tick.
      if (car_mode == MODE_BRAKE && (tick_now - brake_tick) >= cfg_brake) begin
        car_mode = MODE_IDLE;
        set_bridge(PINS_OFF, '0, '0);
      end
      if (car_mode != MODE_IDLE && car_mode != MODE_BRAKE &&
          (tick_now - last_cmd_tick) >= cfg_timeout)
        begin_brake();
      if ((tick_now - beat_tick) >= HEARTBEAT_TICKS_DEF) begin
        beat_tick = tick_now;
        led_on = ~led_on;
      end
    end
    res.pins = bridge_pins;
    res.left_duty = duty_l;
    res.right_duty = duty_r;
    res.mode = car_mode;
    res.speed = car_speed;
    res.led = led_on;
    return res;
  endfunction

  function automatic int draw_wait(input bit idle_on);
    return idle_on ? int'($urandom_range(0, 9)) : 0;
  endfunction

  task automatic push_req(input logic act, input logic [7:0] cmd, input bit drain);
    queued_req_t q;
    q.req.action = act;
    q.req.code = cmd;
    q.drain = drain;
    req_q.push_back(q);
  endtask

  // Waits until every request went through and every result came back.
  task automatic drain_requests();
    while (req_q.size() != 0 || in_valid_i || car_state_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin : drive_requests
    logic nxt_valid;
    queued_req_t nxt;
    nxt_valid = in_valid_i;
    if (req_done) begin
      req_done = 0;
      nxt_valid = 1'b0;
      send_wait = draw_wait(send_idle);
    end
    if (rst_ni && !nxt_valid) begin
      if (send_wait > 0) begin
        send_wait--;
      end else if (req_q.size() != 0 && !(req_q[0].drain && car_state_q.size() != 0)) begin
        nxt = req_q.pop_front();
        action_i <= nxt.req.action;
        code_i <= nxt.req.code;
        nxt_valid = 1'b1;
      end
    end
    in_valid_i <= nxt_valid;
    if (res_done) begin
      res_done = 0;
      recv_wait = draw_wait(recv_idle);
    end
    if (recv_wait > 0) begin
      recv_wait--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : watch_results
    car_state_t want;
    bit in_fire;
    bit out_fire;
    if (rst_ni) begin
      in_fire = in_valid_i && in_ready_o;
      out_fire = out_valid_o && out_ready_i;
      if (out_fire) begin
        res_done = 1;
        if (car_state_q.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = car_state_q.pop_front();
          if (drive_pins_o !== want.pins) begin
            $error("drive_pins expected %0h got %0h", want.pins, drive_pins_o);
            mismatches++;
          end
          if (left_duty_o !== want.left_duty) begin
            $error("left_duty expected %0d got %0d", want.left_duty, left_duty_o);
            mismatches++;
          end
          if (right_duty_o !== want.right_duty) begin
            $error("right_duty expected %0d got %0d", want.right_duty, right_duty_o);
            mismatches++;
          end
          if (sound_number_o !== want.sound) begin
            $error("sound_number expected %0d got %0d", want.sound, sound_number_o);
            mismatches++;
          end
          if (drive_mode_o !== want.mode) begin
            $error("drive_mode expected %0d got %0d", want.mode, drive_mode_o);
            mismatches++;
          end
          if (speed_level_o !== want.speed) begin
            $error("speed_level expected %0d got %0d", want.speed, speed_level_o);
            mismatches++;
          end
          if (run_led_o !== want.led) begin
            $error("run_led expected %0b got %0b", want.led, run_led_o);
            mismatches++;
          end
          if (executed_o !== want.executed) begin
            $error("executed expected %0b got %0b", want.executed, executed_o);
            mismatches++;
          end
        end
      end
      if (in_fire) begin
        car_state_q.push_back(next_car_state(action_i, code_i));
        req_done = 1;
      end
      if (in_fire || out_fire) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [15:0] reg_vals [8];
    logic [7:0] cmd;
    int n;
    int len;
    int pick;
    int budget;
    int tick_pct;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Every operation once under the reset settings, zero and top codes included.
    push_req(1'b0, CODE_ZERO, 0);
    push_req(1'b0, CODE_ZERO, 0);
    push_req(1'b0, CMD_FWD, 0);
    push_req(1'b0, CMD_FWD, 0);
    push_req(1'b0, CMD_UP, 0);
    push_req(1'b0, CMD_UP, 0);
    push_req(1'b0, CMD_DOWN, 0);
    push_req(1'b0, CMD_DOWN, 0);
    push_req(1'b0, CMD_BACK, 0);
    push_req(1'b0, CMD_BACK, 0);
    push_req(1'b0, CMD_LEFT, 0);
    push_req(1'b0, CMD_LEFT, 0);
    push_req(1'b0, CMD_RIGHT, 0);
    push_req(1'b0, CMD_RIGHT, 0);
    push_req(1'b0, CMD_SPINL, 0);
    push_req(1'b0, CMD_SPINL, 0);
    push_req(1'b0, CMD_SPINR, 0);
    push_req(1'b0, CMD_SPINR, 0);
    push_req(1'b0, CMD_BRAKE, 1);
    push_req(1'b0, CMD_BRAKE, 0);
    push_req(1'b0, CODE_TOP, 0);
    push_req(1'b0, CODE_TOP, 0);
    push_req(1'b1, CODE_TOP, 0);
    push_req(1'b1, CODE_ZERO, 0);
    push_req(1'b0, CMD_FWD, 0);
    drain_requests();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        reg_vals[REG_CONFIRM] = 16'd1;
        reg_vals[REG_BASE]    = 16'd0;
        reg_vals[REG_MAX]     = 16'd0;
        reg_vals[REG_MIN]     = 16'd0;
        reg_vals[REG_STEP]    = 16'd0;
        reg_vals[REG_PERIOD]  = 16'd1;
        reg_vals[REG_BRAKE]   = 16'd0;
        reg_vals[REG_TIMEOUT] = 16'd0;
        budget = 120;
        tick_pct = 40;
      end else if (p == 1) begin
        reg_vals[REG_CONFIRM] = 16'd255;
        reg_vals[REG_BASE]    = 16'd4095;
        reg_vals[REG_MAX]     = 16'd4095;
        reg_vals[REG_MIN]     = 16'd4095;
        reg_vals[REG_STEP]    = 16'd4095;
        reg_vals[REG_PERIOD]  = 16'd4095;
        reg_vals[REG_BRAKE]   = 16'hFFFF;
        reg_vals[REG_TIMEOUT] = 16'hFFFF;
        budget = 300;
        tick_pct = 10;
      end else begin
        reg_vals[REG_CONFIRM] = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 8)
                                                                : $urandom_range(1, 3));
        reg_vals[REG_BASE]    = 16'($urandom_range(0, 4095));
        reg_vals[REG_MAX]     = 16'($urandom_range(0, 4095));
        reg_vals[REG_MIN]     = 16'($urandom_range(0, 4095));
        reg_vals[REG_STEP]    = 16'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 4095)
                                                                : $urandom_range(0, 400));
        reg_vals[REG_PERIOD]  = 16'($urandom_range(1, 4095));
        reg_vals[REG_BRAKE]   = 16'($urandom_range(0, 40));
        reg_vals[REG_TIMEOUT] = 16'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                                : $urandom_range(0, 80));
        budget = 128;
        tick_pct = 55;
      end

      for (int idx = 0; idx < 8; idx++) begin
        @(negedge clk_i);
        cfg_we_i <= 1'b1;
        cfg_index_i <= idx[CFG_IDX_W-1:0];
        cfg_data_i <= reg_vals[idx];
        @(negedge clk_i);
        cfg_we_i <= 1'b0;
        case (idx[CFG_IDX_W-1:0])
          REG_CONFIRM: cfg_confirm = reg_vals[idx][7:0];
          REG_BASE:    car_speed = reg_vals[idx][11:0];
          REG_MAX:     cfg_max = reg_vals[idx][11:0];
          REG_MIN:     cfg_min = reg_vals[idx][11:0];
          REG_STEP:    cfg_step = reg_vals[idx][11:0];
          REG_PERIOD:  cfg_period = reg_vals[idx][11:0];
          REG_BRAKE:   cfg_brake = reg_vals[idx];
          REG_TIMEOUT: cfg_timeout = reg_vals[idx];
          default: ;
        endcase
      end

      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);

      // Mostly full confirmation runs of one code with ticks mixed in; the rest
      // are lone ticks, stray codes and runs cut short.
      n = 0;
      while (n < budget) begin
        pick = int'($urandom_range(0, 99));
        if (pick < tick_pct) begin
          push_req(1'b1, 8'($urandom_range(0, 255)), $urandom_range(0, 149) == 0);
          n++;
        end else if (pick < tick_pct + 8) begin
          push_req(1'b0, 8'($urandom_range(0, 255)), 0);
          n++;
        end else begin
          cmd = 8'($urandom_range(0, 11));
          if (cmd > CMD_SPINR) cmd = 8'($urandom_range(10, 255));
          len = (cfg_confirm < 8'd2) ? 2 : int'(cfg_confirm);
          if ($urandom_range(0, 4) == 0) len = int'($urandom_range(1, len - 1));
          else len += int'($urandom_range(0, 1));
          repeat (len) begin
            if ($urandom_range(0, 3) == 0) begin
              push_req(1'b1, 8'($urandom_range(0, 255)), 0);
              n++;
            end
            push_req(1'b0, cmd, $urandom_range(0, 149) == 0);
            n++;
          end
        end
      end
      drain_requests();
    end

    if (mismatches == 0 && car_state_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: confirmed_command_drive_controller.f
design/ccdc_pkg.sv
design/ccdc_cfg.sv
design/ccdc_core.sv
design/confirmed_command_drive_controller.sv
dv/confirmed_command_drive_controller_tb.sv
